### src/assert_macros.svh
// assertion macros of the rolling hash rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RBH_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rolling hash invariant violated");
`define RBH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rolling hash sequence violated");
`else
`define RBH_ASSERT(label, clk, rst_n, cond)
`define RBH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### src/rbh_pkg.sv
// shared constants, register indexes and pipeline item type of the rolling hash
// no dependencies
`timescale 1ns / 1ps

package rbh_pkg;

    localparam int DEF_MAX_WINDOW = 1024;
    localparam int DEF_HASH_WIDTH = 32;
    localparam int WIN_SIZE_W     = 11;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_IDX_W      = 1;
    localparam int BYTE_W         = 8;

    // multiplier 17 = (1 << MULT_SHIFT) + 1
    localparam int MULT_SHIFT = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_COEF   = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              fill;
        logic              emit;
        logic              last;
        logic [BYTE_W-1:0] data;
    } t_item;

endpackage

### src/rbh_window_mem.sv
// byte delay line of the rolling hash: one write and one registered read per enabled cycle
// depends on rbh_pkg
`timescale 1ns / 1ps

module rbh_window_mem #(
    parameter int DEPTH = rbh_pkg::DEF_MAX_WINDOW,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [rbh_pkg::BYTE_W-1:0] i_wr_data,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [rbh_pkg::BYTE_W-1:0] o_rd_data
);

    logic [rbh_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [rbh_pkg::BYTE_W-1:0] r_rd_data;

    // read-first: a read of the entry being written returns the old byte
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_data          <= r_mem[i_rd_addr];
            r_mem[i_wr_addr]   <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/rbh_roll.sv
// product stage, hash update loop and output register of the rolling hash
// depends on rbh_pkg
`timescale 1ns / 1ps

module rbh_roll #(
    parameter int HASH_WIDTH = rbh_pkg::DEF_HASH_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_clear,
    input  rbh_pkg::t_item             i_s1,
    input  logic [rbh_pkg::BYTE_W-1:0] i_rd_data,
    input  logic [HASH_WIDTH-1:0]      i_coef,
    output logic                       o_valid,
    output logic [HASH_WIDTH-1:0]      o_key,
    output logic                       o_final
);

    rbh_pkg::t_item        r_s2;
    logic [HASH_WIDTH-1:0] r_prod;
    logic [HASH_WIDTH-1:0] r_hash;
    logic                  r_out_valid;
    logic [HASH_WIDTH-1:0] r_key;
    logic                  r_final;

    logic [HASH_WIDTH-1:0] n_diff;
    logic [HASH_WIDTH-1:0] n_hash;

    always_comb begin
        n_diff = r_hash - r_prod;
        n_hash = (n_diff << rbh_pkg::MULT_SHIFT) + n_diff + HASH_WIDTH'(r_s2.data);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2        <= '0;
            r_out_valid <= 1'b0;
            r_hash      <= '0;
        end else begin
            if (i_adv) begin
                r_s2        <= i_s1;
                r_out_valid <= r_s2.valid && r_s2.emit;
                if (r_s2.valid) begin
                    r_hash <= r_s2.last ? '0 : n_hash;
                end
            end
            if (i_clear) begin
                r_hash <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // outgoing byte weight; no byte leaves while the window fills
            r_prod  <= i_s1.fill ? '0 : i_coef * HASH_WIDTH'(i_rd_data);
            r_key   <= (n_hash == '1) ? (n_hash >> 1) : n_hash;
            r_final <= r_s2.last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_key   = r_key;
    assign o_final = r_final;

endmodule

### src/rolling_block_hash.sv
// top level of the rolling block hash: configuration, window control and pipeline
// depends on rbh_pkg, rbh_window_mem, rbh_roll and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Rolling polynomial hash (multiplier 17) over a byte stream. The block takes one byte
// every cycle while the output side keeps taking keys; a key is presented once its byte
// has passed the window memory read at the accepting edge, the outgoing-byte product
// and then the hash update into the output register. A key held on the output stalls
// the whole pipeline and the input with it. The sustained rate of one byte per cycle is
// set by the hash update loop and by the one write and one read per cycle of the
// window memory.
// Once window_size bytes of a data set have arrived, every byte gives one key; a byte
// flagged last ends the set. Writing window_size restarts the data set; high_coef must
// be loaded with 17^(window_size-1). No clearing pass is needed after reset.
module rolling_block_hash #(
    parameter int MAX_WINDOW = rbh_pkg::DEF_MAX_WINDOW,
    parameter int HASH_WIDTH = rbh_pkg::DEF_HASH_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [rbh_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                           i_last_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [HASH_WIDTH-1:0]          o_block_key,
    output logic                           o_final_key,
    input  logic                           i_cfg_we,
    input  logic [rbh_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rbh_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int SW = AW + 2;
    localparam logic [CW-1:0] MAX_N   = CW'(MAX_WINDOW);
    localparam logic [AW-1:0] LAST_WP = AW'(MAX_WINDOW - 1);
    localparam logic [SW-1:0] MAX_S   = SW'(MAX_WINDOW);

    logic [CW-1:0]         r_win_n;
    logic [HASH_WIDTH-1:0] r_coef;
    logic [CW-1:0]         r_fill;
    logic [AW-1:0]         r_wp;
    rbh_pkg::t_item        r_s1;

    logic                              adv;
    logic                              accept;
    logic                              fill;
    logic                              emit;
    logic                              win_wr;
    logic [rbh_pkg::WIN_SIZE_W-1:0]    cfg_ws;
    logic [CW-1:0]                     n_win_n;
    logic [SW-1:0]                     rd_sum;
    logic [AW-1:0]                     rd_addr;
    logic [rbh_pkg::BYTE_W-1:0]        rd_data;
    rbh_pkg::t_item                    n_s1;

    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;
    assign accept     = i_in_valid && adv;
    assign win_wr     = i_cfg_we && (i_cfg_idx == rbh_pkg::CFG_WINDOW_SIZE);
    assign cfg_ws     = i_cfg_data[rbh_pkg::WIN_SIZE_W-1:0];

    always_comb begin
        if (cfg_ws == '0) begin
            n_win_n = CW'(1);
        end else if (32'(cfg_ws) > 32'(MAX_WINDOW)) begin
            n_win_n = MAX_N;
        end else begin
            n_win_n = CW'(cfg_ws);
        end
    end

    always_comb begin
        fill   = r_fill < r_win_n;
        emit   = fill ? (CW'(r_fill + 1'b1) == r_win_n) : 1'b1;
        // oldest byte of the window, wp - n modulo the depth
        rd_sum = SW'(r_wp) + MAX_S - SW'(r_win_n);
        if (rd_sum >= MAX_S) begin
            rd_sum = rd_sum - MAX_S;
        end
        rd_addr      = rd_sum[AW-1:0];
        n_s1.valid   = accept;
        n_s1.fill    = fill;
        n_s1.emit    = emit;
        n_s1.last    = i_last_byte;
        n_s1.data    = i_data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_n <= CW'(1);
            r_coef  <= HASH_WIDTH'(1);
            r_fill  <= '0;
            r_wp    <= '0;
            r_s1    <= '0;
        end else begin
            if (adv) begin
                r_s1 <= n_s1;
            end
            if (accept) begin
                if (i_last_byte) begin
                    r_fill <= '0;
                    r_wp   <= '0;
                end else begin
                    if (fill) begin
                        r_fill <= CW'(r_fill + 1'b1);
                    end
                    r_wp <= (r_wp == LAST_WP) ? '0 : AW'(r_wp + 1'b1);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rbh_pkg::CFG_WINDOW_SIZE: begin
                        r_win_n <= n_win_n;
                        r_fill  <= '0;
                        r_wp    <= '0;
                    end
                    rbh_pkg::CFG_HIGH_COEF: begin
                        r_coef <= HASH_WIDTH'(i_cfg_data);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    rbh_window_mem #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_en      (accept),
        .i_wr_addr (r_wp),
        .i_wr_data (i_data_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rbh_roll #(
        .HASH_WIDTH (HASH_WIDTH)
    ) u_roll (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_clear   (win_wr),
        .i_s1      (r_s1),
        .i_rd_data (rd_data),
        .i_coef    (r_coef),
        .o_valid   (o_out_valid),
        .o_key     (o_block_key),
        .o_final   (o_final_key)
    );

    `RBH_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= r_win_n)
    `RBH_ASSERT(a_wp_bound, i_clk, i_rst_n, r_wp <= LAST_WP)
    `RBH_ASSERT_NEXT(a_last_restart, i_clk, i_rst_n, accept && i_last_byte, r_fill == '0 && r_wp == '0)

endmodule
